[rtl/core/icmp_erp_pkg.sv]
// ----------------------------------------------------------------------------
// icmp_erp_pkg
// Shared constants and types for the ICMP echo reply parser.
// ----------------------------------------------------------------------------
package icmp_erp_pkg;

  // Packet and timestamp layout
  localparam int MAX_PACKET_BYTES = 4096;
  localparam int TIME_FIELD_BYTES = 8;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int ILEN_W           = 13;
  localparam int ICMP_HDR_BYTES   = 8;
  localparam int TS_END_BYTES     = ICMP_HDR_BYTES + 2 * TIME_FIELD_BYTES;
  localparam int TTL_POS          = 8;

  // ICMP field offsets inside the ICMP part
  localparam int OFF_TYPE     = 0;
  localparam int OFF_ID_HI    = 4;
  localparam int OFF_ID_LO    = 5;
  localparam int OFF_SEQ_HI   = 6;
  localparam int OFF_SEQ_LO   = 7;
  localparam int KEPT_TS_BYTES = 4;

  // Time arithmetic
  localparam int USEC_PER_SEC = 1000000;
  localparam int MS_PER_SEC   = 1000;
  // floor(x / 125) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2**30
  localparam int            DIV_SHIFT = 37;
  localparam logic [30:0]   DIV_RECIP = 31'd1099511628;
  localparam int            QUOT_W    = 23;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_NOT_OURS = 2'd2,
    ST_NO_TS    = 2'd3
  } status_e;

  // Fields passed through to the result unchanged
  typedef struct packed {
    status_e             status;
    logic [15:0]         seq;
    logic [7:0]          ttl;
    logic [ILEN_W-1:0]   ilen;
  } meta_t;

  // One classified packet waiting for the time math
  typedef struct packed {
    meta_t        meta;
    logic [31:0]  sent_sec;
    logic [31:0]  sent_usec;
    logic [31:0]  now_sec;
    logic [19:0]  now_usec;
  } job_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [QUEUE_CW-1:0] count;
  } q_stat_t;

endpackage

[rtl/core/icmp_erp_front.sv]
// ----------------------------------------------------------------------------
// icmp_erp_front
// Byte-serial header walker: captures IP/ICMP fields and the send timestamp,
// classifies the packet on its last byte and emits one job.
// ----------------------------------------------------------------------------
module icmp_erp_front import icmp_erp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] now_sec_i,
  input  logic [19:0] now_usec_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  logic [15:0]      exp_id_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [3:0]       hw_q, hw_n;
  logic [7:0]       ttl_q, ttl_n;
  logic [7:0]       type_q, type_n;
  logic [15:0]      ident_q, ident_n;
  logic [15:0]      seq_q, seq_n;
  logic [31:0]      sent_sec_q, sent_sec_n;
  logic [31:0]      sent_usec_q, sent_usec_n;

  logic             accept;
  logic             take;
  logic [5:0]       off;
  logic [POS_W-1:0] rel, ks, ku;
  logic [POS_W-1:0] total, hdr, ilen;
  status_e          status;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i & job_ready_i;

  // Field capture for the current byte
  always_comb begin
    hw_n        = hw_q;
    ttl_n       = ttl_q;
    type_n      = type_q;
    ident_n     = ident_q;
    seq_n       = seq_q;
    sent_sec_n  = sent_sec_q;
    sent_usec_n = sent_usec_q;
    take        = pos_q < POS_W'(MAX_PACKET_BYTES);
    if (take && pos_q == '0) begin
      ttl_n       = '0;
      type_n      = '0;
      ident_n     = '0;
      seq_n       = '0;
      sent_sec_n  = '0;
      sent_usec_n = '0;
      hw_n        = data_byte_i[3:0];
    end
    off = {hw_n, 2'b00};
    rel = pos_q - POS_W'(off);
    ks  = rel - POS_W'(ICMP_HDR_BYTES);
    ku  = rel - POS_W'(ICMP_HDR_BYTES + TIME_FIELD_BYTES);
    if (take) begin
      if (pos_q == POS_W'(TTL_POS)) begin
        ttl_n = data_byte_i;
      end
      if (pos_q >= POS_W'(off)) begin
        if (rel == POS_W'(OFF_TYPE)) begin
          type_n = data_byte_i;
        end else if (rel == POS_W'(OFF_ID_HI)) begin
          ident_n[15:8] = data_byte_i;
        end else if (rel == POS_W'(OFF_ID_LO)) begin
          ident_n[7:0] = data_byte_i;
        end else if (rel == POS_W'(OFF_SEQ_HI)) begin
          seq_n[15:8] = data_byte_i;
        end else if (rel == POS_W'(OFF_SEQ_LO)) begin
          seq_n[7:0] = data_byte_i;
        end else if (rel >= POS_W'(ICMP_HDR_BYTES) &&
                     rel < POS_W'(ICMP_HDR_BYTES + TIME_FIELD_BYTES)) begin
          // seconds, little-endian; bytes past the low four are dropped
          if (ks < POS_W'(KEPT_TS_BYTES)) begin
            sent_sec_n[{ks[1:0], 3'b000} +: 8] = data_byte_i;
          end
        end else if (rel >= POS_W'(ICMP_HDR_BYTES + TIME_FIELD_BYTES) &&
                     rel < POS_W'(TS_END_BYTES)) begin
          if (ku < POS_W'(KEPT_TS_BYTES)) begin
            sent_usec_n[{ku[1:0], 3'b000} +: 8] = data_byte_i;
          end
        end
      end
    end
  end

  // Length and classification, first failing test wins
  always_comb begin
    total = take ? pos_q + POS_W'(1) : pos_q;
    hdr   = POS_W'({hw_n, 2'b00});
    ilen  = (total >= hdr) ? total - hdr : '0;
    if (total < hdr || ilen < POS_W'(ICMP_HDR_BYTES)) begin
      status = ST_SHORT;
    end else if (type_n != 8'd0 || ident_n != exp_id_q) begin
      status = ST_NOT_OURS;
    end else if (ilen < POS_W'(TS_END_BYTES)) begin
      status = ST_NO_TS;
    end else begin
      status = ST_OK;
    end
    pos_d = last_byte_i ? '0 : total;
  end

  // Job toward the queue
  assign job_valid_o         = accept & last_byte_i;
  assign job_o.meta.status   = status;
  assign job_o.meta.seq      = seq_n;
  assign job_o.meta.ttl      = ttl_n;
  assign job_o.meta.ilen     = ILEN_W'(ilen);
  assign job_o.sent_sec      = sent_sec_n;
  assign job_o.sent_usec     = sent_usec_n;
  assign job_o.now_sec       = now_sec_i;
  assign job_o.now_usec      = now_usec_i;

  // Capture registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q    <= '0;
      pos_q       <= '0;
      hw_q        <= '0;
      ttl_q       <= '0;
      type_q      <= '0;
      ident_q     <= '0;
      seq_q       <= '0;
      sent_sec_q  <= '0;
      sent_usec_q <= '0;
    end else begin
      if (cfg_we_i) begin
        exp_id_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q       <= pos_d;
        hw_q        <= hw_n;
        ttl_q       <= ttl_n;
        type_q      <= type_n;
        ident_q     <= ident_n;
        seq_q       <= seq_n;
        sent_sec_q  <= sent_sec_n;
        sent_usec_q <= sent_usec_n;
      end
    end
  end

endmodule

[rtl/core/icmp_erp_queue.sv]
// ----------------------------------------------------------------------------
// icmp_erp_queue
// Small job FIFO that decouples the byte walker from the time math.
// ----------------------------------------------------------------------------
module icmp_erp_queue import icmp_erp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    push_data_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  job_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [QUEUE_CW-1:0] count_q;

  assign head_o       = mem_q[rptr_q];
  assign stat_o.full  = count_q == QUEUE_CW'(QUEUE_DEPTH);
  assign stat_o.empty = count_q == '0;
  assign stat_o.count = count_q;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QUEUE_AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QUEUE_CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QUEUE_CW'(1);
      end
    end
  end

endmodule

[rtl/core/icmp_erp_rtt.sv]
// ----------------------------------------------------------------------------
// icmp_erp_rtt
// Four-stage round-trip pipeline: differences, scale and magnitude over 8,
// divide by 125, combine and saturate into the output register.
// ----------------------------------------------------------------------------
module icmp_erp_rtt import icmp_erp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_pop_o,
  input  job_t        job_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output meta_t       meta_o,
  output logic [31:0] rtt_ms_o
);

  logic va_q, vb_q, vc_q, vd_q;
  logic adv_a, adv_b, adv_c, adv_d;

  // stage A
  meta_t              meta_a_q;
  logic signed [32:0] sec_diff_q;
  logic signed [32:0] usec_diff_q;
  logic               borrow;
  logic [32:0]        sec_diff_d, usec_diff_d;
  // stage B
  meta_t              meta_b_q;
  logic signed [42:0] sec_ms_b_q;
  logic               neg_b_q;
  logic [28:0]        div8_q;
  logic signed [42:0] sec_ext;
  logic [32:0]        usec_mag;
  // stage C
  meta_t              meta_c_q;
  logic signed [42:0] sec_ms_c_q;
  logic               neg_c_q;
  logic [QUOT_W-1:0]  quot_q;
  logic [59:0]        prod;
  // stage D
  meta_t              meta_d_q;
  logic [31:0]        rtt_q;
  logic signed [43:0] q_ext, sum;
  logic [31:0]        rtt_d;

  // Stall chain, output register last
  assign adv_d     = !vd_q || out_ready_i;
  assign adv_c     = !vc_q || adv_d;
  assign adv_b     = !vb_q || adv_c;
  assign adv_a     = !va_q || adv_b;
  assign job_pop_o = job_valid_i && adv_a;

  // Stage A: seconds and microseconds differences with borrow
  always_comb begin
    borrow      = {12'b0, job_i.now_usec} < job_i.sent_usec;
    sec_diff_d  = {1'b0, job_i.now_sec} - {1'b0, job_i.sent_sec} - {32'b0, borrow};
    usec_diff_d = {13'b0, job_i.now_usec} - {1'b0, job_i.sent_usec} +
                  (borrow ? 33'(USEC_PER_SEC) : 33'd0);
  end

  // Stage B: seconds to ms, microsecond magnitude over 8
  always_comb begin
    sec_ext  = 43'(sec_diff_q);
    usec_mag = usec_diff_q[32] ? 33'(-usec_diff_q) : 33'(usec_diff_q);
  end

  // Stage C: divide by 125 through the reciprocal
  assign prod = 60'(div8_q) * 60'(DIV_RECIP);

  // Stage D: combine with truncation toward zero and saturate
  always_comb begin
    q_ext = $signed({21'b0, quot_q});
    sum   = 44'(sec_ms_c_q) + (neg_c_q ? -q_ext : q_ext);
    if (sum[43]) begin
      rtt_d = '0;
    end else if (sum[42:32] != '0) begin
      rtt_d = '1;
    end else begin
      rtt_d = sum[31:0];
    end
    if (meta_c_q.status != ST_OK) begin
      rtt_d = '0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv_a && job_valid_i) begin
      meta_a_q    <= job_i.meta;
      sec_diff_q  <= $signed(sec_diff_d);
      usec_diff_q <= $signed(usec_diff_d);
    end
    if (adv_b && va_q) begin
      meta_b_q   <= meta_a_q;
      sec_ms_b_q <= sec_ext * $signed(43'(MS_PER_SEC));
      neg_b_q    <= usec_diff_q[32];
      div8_q     <= usec_mag[31:3];
    end
    if (adv_c && vb_q) begin
      meta_c_q   <= meta_b_q;
      sec_ms_c_q <= sec_ms_b_q;
      neg_c_q    <= neg_b_q;
      quot_q     <= prod[DIV_SHIFT +: QUOT_W];
    end
    if (adv_d && vc_q) begin
      meta_d_q <= meta_c_q;
      rtt_q    <= rtt_d;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (adv_a) begin
        va_q <= job_valid_i;
      end
      if (adv_b) begin
        vb_q <= va_q;
      end
      if (adv_c) begin
        vc_q <= vb_q;
      end
      if (adv_d) begin
        vd_q <= vc_q;
      end
    end
  end

  assign out_valid_o = vd_q;
  assign meta_o      = meta_d_q;
  assign rtt_ms_o    = rtt_q;

endmodule

[rtl/core/icmp_echo_reply_parser.sv]
// ----------------------------------------------------------------------------
// icmp_echo_reply_parser
// Parses a received IPv4 packet byte by byte and reports one echo reply
// result per packet, with round-trip time in milliseconds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one packet byte per item,
//   with last_byte_i on the final byte; now_sec_i/now_usec_i are sampled
//   with that last byte. One byte is taken every cycle while the job queue is not full.
//   Output channel (out_valid_o/out_ready_i) carries one result per packet:
//   status, sequence, TTL, ICMP length and saturated RTT.
//   cfg_we_i/cfg_wdata_i load the expected ICMP identifier; write it idle.
//   When its last byte is accepted the job enters the queue, then passes
//   the four time-math stages, ending in the output register.
//   Throughput: one byte per cycle while the queue has room; one result
//   per cycle out of the back pipeline while out_ready_i is high, so
//   back-to-back one-byte packets stream without stalls.
//   A 4-entry job queue sits between the byte walker and the time math;
//   when the receiver stalls the pipeline holds, the queue fills, and only
//   then in_ready_o drops.
//   Reset clears the byte counter, captures, identifier and all valid bits.
// ----------------------------------------------------------------------------
module icmp_echo_reply_parser import icmp_erp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [31:0]       now_sec_i,
  input  logic [19:0]       now_usec_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [15:0]       echo_seq_o,
  output logic [7:0]        ip_ttl_o,
  output logic [ILEN_W-1:0] icmp_length_o,
  output logic [31:0]       rtt_ms_o
);

  logic    push;
  job_t    push_job;
  job_t    head_job;
  logic    pop;
  q_stat_t q_stat;
  meta_t   meta;

  icmp_erp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .now_sec_i   (now_sec_i),
    .now_usec_i  (now_usec_i),
    .job_valid_o (push),
    .job_ready_i (!q_stat.full),
    .job_o       (push_job)
  );

  icmp_erp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .stat_o      (q_stat)
  );

  icmp_erp_rtt u_rtt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_stat.empty),
    .job_pop_o   (pop),
    .job_i       (head_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .meta_o      (meta),
    .rtt_ms_o    (rtt_ms_o)
  );

  assign status_o      = meta.status;
  assign echo_seq_o    = meta.seq;
  assign ip_ttl_o      = meta.ttl;
  assign icmp_length_o = meta.ilen;

  // A nonzero round trip only comes with an accepted echo reply
  a_rtt_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> rtt_ms_o == '0)
    else $error("rtt nonzero on a rejected packet");

  // A short ICMP part must be reported as too short
  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && icmp_length_o < ILEN_W'(ICMP_HDR_BYTES) |-> status_o == ST_SHORT)
    else $error("short packet not classified as short");

  // Queue fill never exceeds its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("job queue overflow");

  // A full queue with a pending push is never accepted
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full && !pop |=> q_stat.count == QUEUE_CW'(QUEUE_DEPTH))
    else $error("job queue lost an entry while full");

endmodule

[dv/tb_icmp_echo_reply_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_icmp_echo_reply_parser
// Feeds IPv4 packets byte by byte into the echo reply parser and compares each
// reply against a cycle-free model of the byte walker and the RTT math. Covers
// every status code, header lengths, time borrow and saturation,
// expected-id settings, output back-pressure and random traffic with idling.
// ----------------------------------------------------------------------------
module tb_icmp_echo_reply_parser;
  import icmp_erp_pkg::*;

  localparam int     DRAIN_CYCLES = 10;
  localparam int     DRAIN_LIMIT  = 5000;
  localparam int     HOLD_CYCLES  = 120;
  localparam longint RTT_MAX      = 64'd4294967295;

  typedef struct packed {
    status_e           status;
    logic [15:0]       seq;
    logic [7:0]        ttl;
    logic [ILEN_W-1:0] ilen;
    logic [31:0]       rtt;
  } echo_reply_t;

  // DUT signals
  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [15:0]       cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        data_byte_i;
  logic              last_byte_i;
  logic [31:0]       now_sec_i;
  logic [19:0]       now_usec_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [15:0]       echo_seq_o;
  logic [7:0]        ip_ttl_o;
  logic [ILEN_W-1:0] icmp_length_o;
  logic [31:0]       rtt_ms_o;

  // Walker state mirrored from the block
  logic [15:0]  cfg_id        = '0;
  int unsigned  walk_pos      = 0;
  logic [3:0]   ihl_cap       = '0;
  logic [7:0]   ttl_cap       = '0;
  logic [7:0]   type_cap      = '0;
  logic [15:0]  ident_cap     = '0;
  logic [15:0]  seq_cap       = '0;
  logic [31:0]  sent_sec_cap  = '0;
  logic [31:0]  sent_usec_cap = '0;

  echo_reply_t  pending_replies[$];
  logic [7:0]   pkt_buf[$];

  // Pacing and bookkeeping
  int tx_idle_pct     = 0;
  int rx_idle_pct     = 0;
  int rx_hold_req     = 0;
  int mismatches      = 0;
  int replies_checked = 0;
  int bytes_sent      = 0;
  int packets_sent    = 0;
  int id_settings     = 0;
  int in_stall_cycles = 0;

  icmp_echo_reply_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .now_sec_i     (now_sec_i),
    .now_usec_i    (now_usec_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .echo_seq_o    (echo_seq_o),
    .ip_ttl_o      (ip_ttl_o),
    .icmp_length_o (icmp_length_o),
    .rtt_ms_o      (rtt_ms_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin : watchdog
    #(10ms);
    $display("tb_icmp_echo_reply_parser NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    // keep the log readable on a badly broken block
    if (mismatches <= 200)
      $display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
  endtask

  // RTT in ms with borrow, truncating usec quotient, saturated to 32 bits
  function automatic logic [31:0] round_trip_ms(input logic [31:0] nsec,
                                                input logic [19:0] nusec);
    longint dsec, dusec, ms, a, b;
    a = nsec;
    b = sent_sec_cap;
    dsec = a - b;
    a = nusec;
    b = sent_usec_cap;
    dusec = a - b;
    if ({12'd0, nusec} < sent_usec_cap) begin
      dsec  = dsec - 1;
      dusec = dusec + USEC_PER_SEC;
    end
    ms = dsec * MS_PER_SEC + dusec / MS_PER_SEC;
    if (ms < 0) return '0;
    if (ms > RTT_MAX) return '1;
    return ms[31:0];
  endfunction

  // Advance the walker by one byte; on the last byte queue the expected reply
  function automatic void walk_packet_byte(input logic [7:0] b, input logic is_last,
                                           input logic [31:0] nsec, input logic [19:0] nusec);
    int unsigned hdr, off, total, ilen;
    echo_reply_t rep;
    if (walk_pos < MAX_PACKET_BYTES) begin
      if (walk_pos == 0) begin
        ttl_cap       = '0;
        type_cap      = '0;
        ident_cap     = '0;
        seq_cap       = '0;
        sent_sec_cap  = '0;
        sent_usec_cap = '0;
        ihl_cap       = b[3:0];
      end
      if (walk_pos == TTL_POS) ttl_cap = b;
      hdr = 4 * ihl_cap;
      if (walk_pos >= hdr) begin
        off = walk_pos - hdr;
        if (off == OFF_TYPE) type_cap = b;
        else if (off == OFF_ID_HI) ident_cap[15:8] = b;
        else if (off == OFF_ID_LO) ident_cap[7:0] = b;
        else if (off == OFF_SEQ_HI) seq_cap[15:8] = b;
        else if (off == OFF_SEQ_LO) seq_cap[7:0] = b;
        else if (off >= ICMP_HDR_BYTES && off < ICMP_HDR_BYTES + TIME_FIELD_BYTES) begin
          // only the low four bytes of a wide field are kept
          if (off - ICMP_HDR_BYTES < KEPT_TS_BYTES)
            sent_sec_cap[8*(off-ICMP_HDR_BYTES) +: 8] = b;
        end else if (off >= ICMP_HDR_BYTES + TIME_FIELD_BYTES && off < TS_END_BYTES) begin
          if (off - ICMP_HDR_BYTES - TIME_FIELD_BYTES < KEPT_TS_BYTES)
            sent_usec_cap[8*(off-ICMP_HDR_BYTES-TIME_FIELD_BYTES) +: 8] = b;
        end
      end
      walk_pos++;
    end
    if (!is_last) return;

    total    = walk_pos;
    walk_pos = 0;
    hdr      = 4 * ihl_cap;
    ilen     = (total >= hdr) ? total - hdr : 0;
    rep.rtt  = '0;
    if (total < hdr || ilen < ICMP_HDR_BYTES) rep.status = ST_SHORT;
    else if (type_cap != 8'd0 || ident_cap != cfg_id) rep.status = ST_NOT_OURS;
    else if (ilen < TS_END_BYTES) rep.status = ST_NO_TS;
    else begin
      rep.status = ST_OK;
      rep.rtt    = round_trip_ms(nsec, nusec);
    end
    rep.seq  = seq_cap;
    rep.ttl  = ttl_cap;
    rep.ilen = ILEN_W'(ilen);
    pending_replies.insert(pending_replies.size(), rep);
  endfunction

  // Offer one byte; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic is_last,
                           input logic [31:0] nsec, input logic [19:0] nusec);
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    data_byte_i <= b;
    last_byte_i <= is_last;
    now_sec_i   <= nsec;
    now_usec_i  <= nusec;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    walk_packet_byte(b, is_last, nsec, nusec);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send pkt_buf as one packet; time inputs only matter on the last byte
  task automatic send_packet(input logic [31:0] nsec, input logic [19:0] nusec);
    int k;
    for (k = 0; k < pkt_buf.size(); k++) begin
      if (k == pkt_buf.size() - 1) send_byte(pkt_buf[k], 1'b1, nsec, nusec);
      else send_byte(pkt_buf[k], 1'b0, $urandom, 20'($urandom_range(0, 999999)));
    end
    packets_sent++;
  endtask

  task automatic send_noise(input int len);
    int k;
    pkt_buf.delete();
    for (k = 0; k < len; k++) pkt_buf.insert(pkt_buf.size(), 8'($urandom));
    send_packet($urandom, 20'($urandom_range(0, 999999)));
  endtask

  // Build an IPv4 + ICMP echo packet, optionally cut to keep bytes, and send it
  task automatic send_echo(input int ihl, input logic [7:0] msg_type,
                           input logic [15:0] ident, input logic [15:0] seq,
                           input logic [31:0] sent_sec, input logic [31:0] sent_usec,
                           input int extra, input int keep,
                           input logic [31:0] nsec, input logic [19:0] nusec);
    int k;
    pkt_buf.delete();
    for (k = 0; k < 4 * ihl; k++) pkt_buf.insert(pkt_buf.size(), 8'($urandom));
    if (ihl != 0) pkt_buf[0] = {4'h4, 4'(ihl)};
    pkt_buf.insert(pkt_buf.size(), msg_type);
    // code and checksum are not looked at
    for (k = 0; k < 3; k++) pkt_buf.insert(pkt_buf.size(), 8'($urandom));
    pkt_buf.insert(pkt_buf.size(), ident[15:8]);
    pkt_buf.insert(pkt_buf.size(), ident[7:0]);
    pkt_buf.insert(pkt_buf.size(), seq[15:8]);
    pkt_buf.insert(pkt_buf.size(), seq[7:0]);
    for (k = 0; k < TIME_FIELD_BYTES; k++)
      pkt_buf.insert(pkt_buf.size(), k < KEPT_TS_BYTES ? sent_sec[8*k +: 8] : 8'($urandom));
    for (k = 0; k < TIME_FIELD_BYTES; k++)
      pkt_buf.insert(pkt_buf.size(), k < KEPT_TS_BYTES ? sent_usec[8*k +: 8] : 8'($urandom));
    for (k = 0; k < extra; k++) pkt_buf.insert(pkt_buf.size(), 8'($urandom));
    while (keep > 0 && pkt_buf.size() > keep) void'(pkt_buf.pop_back());
    send_packet(nsec, nusec);
  endtask

  // Stop offering, wait for every reply, then let the pipeline settle
  task automatic drain_replies();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_replies.size() != 0) begin
      report_mismatch("replies never came", 32'(pending_replies.size()), 32'd0);
      pending_replies.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_expected_id(input logic [15:0] id);
    drain_replies();
    cfg_wdata_i <= id;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_id       = id;
    id_settings++;
  endtask

  // Random packet: mostly well-formed replies, some cut short, some noise
  task automatic send_random_packet();
    int kind, ihl, extra, keep;
    logic [7:0]  msg_type;
    logic [15:0] ident;
    logic [31:0] sent_sec, sent_usec, nsec;
    kind      = $urandom_range(0, 99);
    ihl       = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
    msg_type  = ($urandom_range(0, 99) < 85) ? 8'd0 : 8'($urandom);
    ident     = ($urandom_range(0, 99) < 85) ? cfg_id : 16'($urandom);
    sent_sec  = $urandom;
    sent_usec = ($urandom_range(0, 9) != 0) ? 32'($urandom_range(0, 999999)) : $urandom;
    nsec      = ($urandom_range(0, 4) != 0) ? sent_sec + $urandom_range(0, 5) : $urandom;
    extra     = $urandom_range(0, 12);
    keep      = 0;
    if (kind >= 93) send_noise(1);
    else if (kind >= 85) send_noise($urandom_range(2, 30));
    else begin
      if (kind >= 65) keep = $urandom_range(1, 4 * ihl + TS_END_BYTES + extra);
      send_echo(ihl, msg_type, ident, 16'($urandom), sent_sec, sent_usec, extra, keep,
                nsec, 20'($urandom_range(0, 999999)));
    end
  endtask

  // Expected id resets to zero
  task automatic test_reset_defaults();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_echo(5, 8'd0, 16'h0000, 16'h0001, 32'd100, 32'd500000, 0, 0, 32'd101, 20'd250000);
    send_echo(5, 8'd0, 16'h0001, 16'h0002, 32'd100, 32'd0, 0, 0, 32'd101, 20'd0);
  endtask

  // One packet per status code, plus the precedence between them
  task automatic test_status_codes();
    write_expected_id(16'h1234);
    send_echo(5, 8'd0, 16'h1234, 16'hFFFF, 32'd10, 32'd0, 4, 0, 32'd12, 20'd999999);
    send_echo(5, 8'd0, 16'h1234, 16'h0000, 32'd10, 32'd0, 0, 27, 32'd12, 20'd0);
    send_echo(15, 8'd0, 16'h1234, 16'h0003, 32'd10, 32'd0, 0, 10, 32'd12, 20'd0);
    send_echo(5, 8'd8, 16'h1234, 16'h0004, 32'd10, 32'd0, 0, 0, 32'd12, 20'd0);
    send_echo(5, 8'd0, 16'h1235, 16'h0005, 32'd10, 32'd0, 0, 0, 32'd12, 20'd0);
    send_echo(5, 8'hFF, 16'h0000, 16'h0006, 32'd10, 32'd0, 0, 25, 32'd12, 20'd0);
    send_echo(5, 8'd0, 16'h1234, 16'h0007, 32'd10, 32'd0, 0, 43, 32'd12, 20'd0);
    send_echo(5, 8'd0, 16'h1234, 16'h0008, 32'd10, 32'd0, 0, 0, 32'd12, 20'd0);
    send_noise(1);
  endtask

  // Borrow, equal times, negative and huge differences, odd microseconds
  task automatic test_time_math();
    send_echo(5, 8'd0, 16'h1234, 16'h0100, 32'd1000, 32'd999999, 0, 0, 32'd1001, 20'd0);
    send_echo(5, 8'd0, 16'h1234, 16'h0101, 32'd5, 32'd250000, 0, 0, 32'd5, 20'd250000);
    send_echo(5, 8'd0, 16'h1234, 16'h0102, 32'd2000, 32'd0, 0, 0, 32'd1999, 20'd999999);
    send_echo(5, 8'd0, 16'h1234, 16'h0103, 32'd0, 32'd0, 0, 0, 32'hFFFF_FFFF, 20'd999999);
    send_echo(5, 8'd0, 16'h1234, 16'h0104, 32'd7, 32'hFFFF_FFFF, 0, 0, 32'd9, 20'd0);
    send_echo(5, 8'd0, 16'h1234, 16'h0105, 32'd100, 32'h000F_FFFF, 0, 0, 32'd200, 20'd0);
    send_echo(5, 8'd0, 16'h1234, 16'h0106, 32'd123, 32'd456789, 0, 0, 32'd4000123,
              20'd456788);
  endtask

  // Header lengths down to zero (ICMP starts at byte 0) and up to 60 bytes
  task automatic test_header_lengths();
    send_echo(0, 8'd0, 16'h1234, 16'h0200, 32'd50, 32'd10, 2, 0, 32'd51, 20'd20);
    send_echo(1, 8'd0, 16'h1234, 16'h0201, 32'd50, 32'd10, 0, 0, 32'd51, 20'd20);
    send_echo(2, 8'd0, 16'h1234, 16'h0202, 32'd50, 32'd10, 0, 0, 32'd51, 20'd20);
    send_echo(3, 8'd0, 16'h1234, 16'h0203, 32'd50, 32'd10, 0, 0, 32'd51, 20'd20);
    send_echo(15, 8'd0, 16'h1234, 16'h0204, 32'd50, 32'd10, 1, 0, 32'd51, 20'd20);
  endtask

  // Extreme and ordinary expected ids, each with a matching and a foreign reply
  task automatic test_config_sweep();
    logic [15:0] ids[4];
    int i;
    ids = '{16'hFFFF, 16'h0000, 16'h8001, 16'($urandom)};
    for (i = 0; i < 4; i++) begin
      write_expected_id(ids[i]);
      send_echo(5, 8'd0, ids[i], 16'($urandom), 32'd1, 32'd1, 0, 0, 32'd2, 20'd2);
      send_echo(5, 8'd0, ~ids[i], 16'($urandom), 32'd1, 32'd1, 0, 0, 32'd2, 20'd2);
    end
  endtask

  // Receiver stalls long enough that the job queue fills and input stalls
  task automatic test_input_backpressure();
    int i;
    drain_replies();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = HOLD_CYCLES;
    for (i = 0; i < 40; i++) send_noise(1);
    send_echo(5, 8'd0, cfg_id, 16'h0300, 32'd9, 32'd9, 0, 0, 32'd10, 20'd10);
    for (i = 0; i < 10; i++) send_noise(1);
    drain_replies();
  endtask

  // Random traffic in phases with a fresh id each; the last phase runs flat out
  task automatic test_random_traffic();
    int phase, budget_end;
    for (phase = 0; phase < 4; phase++) begin
      write_expected_id(16'($urandom));
      tx_idle_pct = 15;
      rx_idle_pct = 15;
      if (phase == 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      budget_end = bytes_sent + 90;
      while (bytes_sent < budget_end) begin
        if (phase != 3 && $urandom_range(0, 7) == 0) begin
          tx_idle_pct = 15 * $urandom_range(0, 2);
          rx_idle_pct = 15 * $urandom_range(0, 2);
        end
        send_random_packet();
      end
    end
  endtask

  // Receiver pacing: long hold on request, otherwise random stall bursts
  initial begin : rx_pacing
    int stall_left, hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        stall_left   = $urandom_range(1, 10) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Input stalls seen while offering an item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_ready_o) in_stall_cycles++;
  end

  // Compare each accepted reply with the oldest expected one
  always @(posedge clk_i) begin : reply_check
    echo_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply, status", 32'(status_o), 32'd0);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (echo_seq_o !== want.seq)
          report_mismatch("echo_seq", 32'(echo_seq_o), 32'(want.seq));
        if (ip_ttl_o !== want.ttl)
          report_mismatch("ip_ttl", 32'(ip_ttl_o), 32'(want.ttl));
        if (icmp_length_o !== want.ilen)
          report_mismatch("icmp_length", 32'(icmp_length_o), 32'(want.ilen));
        if (rtt_ms_o !== want.rtt) report_mismatch("rtt_ms", rtt_ms_o, want.rtt);
        replies_checked++;
      end
    end
  end

  initial begin
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    now_sec_i   = '0;
    now_usec_i  = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_status_codes();
    test_time_math();
    test_header_lengths();
    test_config_sweep();
    test_input_backpressure();
    test_random_traffic();
    drain_replies();

    $display("Run covered %0d packets (%0d bytes) and %0d replies over %0d id settings",
             packets_sent, bytes_sent, replies_checked, id_settings + 1);
    $display("Input was held off for %0d cycles by output back-pressure, %0d mismatches",
             in_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("tb_icmp_echo_reply_parser OK");
    end else begin
      $display("tb_icmp_echo_reply_parser NOT OK");
    end
    $finish;
  end

endmodule
